// ===== design/fsfl_pkg.sv =====
// ----------------------------------------------------------------------------
// Fixed-slot free-list allocator package
// Word types, operation codes and status codes used by the allocator module.
// ----------------------------------------------------------------------------
package fsfl_pkg;

  // Slot indices are 8 bits; counters hold up to 511.
  localparam int unsigned SLOT_W  = 8;
  localparam int unsigned COUNT_W = 9;
  localparam int unsigned BLOCK_W = 5;

  // Total slot space and counter saturation point.
  localparam logic [COUNT_W-1:0] SLOT_LIMIT = 9'd256;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = 9'd511;

  // Operation codes.
  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;
  localparam logic [1:0] MODE_CLEAR = 2'd3;

  // Status codes.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_EXHAUSTED = 2'd1;
  localparam logic [1:0] STATUS_NULL_FREE = 2'd2;
  localparam logic [1:0] STATUS_NONE_USED = 2'd3;

  // One operation word.
  typedef struct packed {
    logic [1:0]        mode;
    logic [SLOT_W-1:0] slot;
    logic              slot_present;
  } in_word_t;

  // One result word.
  typedef struct packed {
    logic [SLOT_W-1:0]  given_slot;
    logic [1:0]         status;
    logic               in_pool;
    logic               grew;
    logic               grow_warning;
    logic [COUNT_W-1:0] used_count;
    logic [COUNT_W-1:0] high_water;
    logic [BLOCK_W-1:0] blocks_open;
  } out_word_t;

  // One free-list link entry: the slot below a pushed slot and whether it exists.
  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] slot;
  } link_t;

endpackage

// ===== design/fsfl_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with enable and registered read data.
// ----------------------------------------------------------------------------
module fsfl_ram #(
  parameter int unsigned WIDTH = 9,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the data holds while no read is enabled.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/fixed_slot_free_list_allocator.sv =====
// ----------------------------------------------------------------------------
// Fixed-slot free-list allocator
// Hands out slot indices from a pool that grows by whole blocks, recycling
// freed slots through a last-in-first-out list kept in a link RAM.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_stall, in_word) carries one operation
//   word: allocate, free, query or clear. The result channel (out_valid,
//   out_stall, out_word) returns exactly one result word per operation, in
//   order. The configuration port (cfg_wr_en, cfg_wr_data) sets the grow
//   warning enable; the user must write it only while the block is idle,
//   which the block itself does not enforce. An accepted word's result is
//   registered in the output register, or in the skid register while the
//   output is held. One word can be accepted in every cycle while in_stall
//   is low; a pop reads the link RAM to prefetch the link of the new head.
//   When the receiver stalls, the result waits in the output register and
//   one more result is held in a skid register; in_stall rises only when
//   both are full.
//   Reset empties the free list, closes all blocks and clears the counters
//   and the warning enable. The link RAM needs no clearing pass, since an
//   entry is read only after a free has written it.
// ----------------------------------------------------------------------------
module fixed_slot_free_list_allocator #(
  parameter int unsigned SLOTS_PER_BLOCK = 16,
  parameter int unsigned MAX_BLOCKS      = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fsfl_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output fsfl_pkg::out_word_t out_word,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data
);

  import fsfl_pkg::*;

  localparam int unsigned OB_W  = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned SPB_W = $clog2(SLOTS_PER_BLOCK + 1);
  localparam int unsigned CAP_W = (OB_W + SPB_W > 10) ? (OB_W + SPB_W) : 10;
  localparam int unsigned LINK_DEPTH = 2 ** SLOT_W;

  // Allocator state.
  logic [SLOT_W-1:0]  head_r, head_nxt;
  logic               head_v_r, head_v_nxt;
  link_t              link_r, link_nxt;
  logic               link_ram_r, link_ram_nxt;
  logic [COUNT_W-1:0] fresh_r, fresh_nxt;
  logic [OB_W-1:0]    open_r, open_nxt;
  logic [COUNT_W-1:0] used_r, used_nxt;
  logic [COUNT_W-1:0] peak_r, peak_nxt;
  logic               warn_en_r;

  // Output register and skid register.
  out_word_t out_r, skid_r;
  logic      out_v_r, skid_v_r;

  // Link RAM ports.
  logic  ram_wr_en;
  logic  ram_rd_en;
  link_t ram_rd_data;

  logic      in_fire, out_fire;
  out_word_t res;
  link_t     link_eff;

  logic [CAP_W-1:0]   cap_raw;
  logic [COUNT_W-1:0] cap;
  logic               growable;
  logic               member;

  assign in_fire  = in_valid && !skid_v_r;
  assign out_fire = out_v_r && !out_stall;

  assign in_stall  = skid_v_r;
  assign out_valid = out_v_r;
  assign out_word  = out_r;

  // Link of the current head: from the prefetching RAM read or a register.
  assign link_eff = link_ram_r ? ram_rd_data : link_r;

  // Capacity of the opened blocks, clipped to the slot space.
  assign cap_raw  = CAP_W'(open_r) * CAP_W'(SLOTS_PER_BLOCK);
  assign cap      = (cap_raw > CAP_W'(SLOT_LIMIT)) ? SLOT_LIMIT : cap_raw[COUNT_W-1:0];
  assign growable = (open_r < OB_W'(MAX_BLOCKS)) && (cap_raw < CAP_W'(SLOT_LIMIT));
  assign member   = {1'b0, in_word.slot} < cap;

  // Operation logic: next state and the result word.
  always_comb begin
    head_nxt     = head_r;
    head_v_nxt   = head_v_r;
    link_nxt     = link_r;
    link_ram_nxt = link_ram_r;
    fresh_nxt    = fresh_r;
    open_nxt     = open_r;
    used_nxt     = used_r;
    peak_nxt     = peak_r;
    ram_wr_en    = 1'b0;
    ram_rd_en    = 1'b0;

    res.given_slot   = '0;
    res.status       = STATUS_OK;
    res.in_pool      = 1'b0;
    res.grew         = 1'b0;
    res.grow_warning = 1'b0;

    if (in_fire) begin
      unique case (in_word.mode)
        MODE_ALLOC: begin
          if (head_v_r) begin
            // Pop the head and prefetch the link of the new head.
            res.given_slot = head_r;
            head_nxt       = link_eff.slot;
            head_v_nxt     = link_eff.valid;
            ram_rd_en      = link_eff.valid;
            link_ram_nxt   = link_eff.valid;
            if (used_r != COUNT_MAX) begin
              used_nxt = used_r + 1'b1;
            end
          end else if ((fresh_r < cap) || growable) begin
            // Hand out the next never-used slot, opening a block if needed.
            if (fresh_r >= cap) begin
              res.grew         = 1'b1;
              res.grow_warning = (open_r != '0) && warn_en_r;
              open_nxt         = open_r + 1'b1;
            end
            res.given_slot = fresh_r[SLOT_W-1:0];
            fresh_nxt      = fresh_r + 1'b1;
            if (used_r != COUNT_MAX) begin
              used_nxt = used_r + 1'b1;
            end
          end else begin
            res.status = STATUS_EXHAUSTED;
          end
        end
        MODE_FREE: begin
          if (!in_word.slot_present) begin
            res.status = STATUS_NULL_FREE;
          end else if (used_r == '0) begin
            res.status = STATUS_NONE_USED;
          end else begin
            // Push the slot; the old head becomes its link.
            used_nxt       = used_r - 1'b1;
            ram_wr_en      = 1'b1;
            link_nxt.valid = head_v_r;
            link_nxt.slot  = head_r;
            link_ram_nxt   = 1'b0;
            head_nxt       = in_word.slot;
            head_v_nxt     = 1'b1;
          end
        end
        MODE_QUERY: begin
          res.in_pool = member;
        end
        MODE_CLEAR: begin
          head_nxt     = '0;
          head_v_nxt   = 1'b0;
          link_ram_nxt = 1'b0;
          fresh_nxt    = '0;
          open_nxt     = '0;
          used_nxt     = '0;
        end
        default: begin
        end
      endcase
    end

    if (used_nxt > peak_r) begin
      peak_nxt = used_nxt;
    end

    res.used_count  = used_nxt;
    res.high_water  = peak_nxt;
    res.blocks_open = BLOCK_W'(open_nxt);
  end

  // Link RAM: written by a free at the freed slot, read at the new head.
  fsfl_ram #(
    .WIDTH ($bits(link_t)),
    .DEPTH (LINK_DEPTH)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (in_word.slot),
    .wr_data ({head_v_r, head_r}),
    .rd_en   (ram_rd_en),
    .rd_addr (link_eff.slot),
    .rd_data (ram_rd_data)
  );

  // Allocator state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      head_v_r   <= 1'b0;
      link_ram_r <= 1'b0;
      fresh_r    <= '0;
      open_r     <= '0;
      used_r     <= '0;
      peak_r     <= '0;
      warn_en_r  <= 1'b0;
    end else begin
      head_r     <= head_nxt;
      head_v_r   <= head_v_nxt;
      link_ram_r <= link_ram_nxt;
      fresh_r    <= fresh_nxt;
      open_r     <= open_nxt;
      used_r     <= used_nxt;
      peak_r     <= peak_nxt;
      if (cfg_wr_en) begin
        warn_en_r <= cfg_wr_data;
      end
    end
  end

  // The held link of the head needs no reset; it is used only with a valid head.
  always_ff @(posedge clk) begin
    link_r <= link_nxt;
  end

  // Output valid flags: the skid register fills only when the output is held.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_fire) begin
        skid_v_r <= 1'b0;
      end
    end else if (in_fire) begin
      if (out_v_r && !out_fire) begin
        skid_v_r <= 1'b1;
      end else begin
        out_v_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_v_r <= 1'b0;
    end
  end

  // Output and skid payload.
  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_fire) begin
        out_r <= skid_r;
      end
    end else if (in_fire) begin
      if (out_v_r && !out_fire) begin
        skid_r <= res;
      end else begin
        out_r <= res;
      end
    end
  end

`ifndef ASSERT_OFF
  // A full skid register implies a waiting output word.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid register full while output register empty");

  // A prefetched link from the RAM is only pending for a valid head.
  a_prefetch_head: assert property (@(posedge clk) disable iff (!rst_n)
    link_ram_r |-> head_v_r)
    else $error("RAM link pending with an empty free list");

  // An accepted push leaves a valid head equal to the freed slot.
  a_push_head: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_word.mode == MODE_FREE) && in_word.slot_present && (used_r != '0))
    |=> (head_v_r && (head_r == $past(in_word.slot))))
    else $error("free did not push the slot onto the list");

  // A clear empties the list and closes the pool.
  a_clear_pool: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_word.mode == MODE_CLEAR))
    |=> (!head_v_r && (fresh_r == '0) && (open_r == '0) && (used_r == '0)))
    else $error("clear left pool state behind");

  // The high-water mark never falls below the in-use count.
  a_peak_bound: assert property (@(posedge clk) disable iff (!rst_n)
    peak_r >= used_r)
    else $error("high-water mark below slots in use");
`endif

endmodule
